/* rtl/csdt_pkg.sv */
package csdt_pkg;

  localparam int MAX_SEGMENTS = 1024;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
  localparam int AMOUNT_W     = 32;
  localparam int PREFIX_W     = 42;
  localparam int TOTAL_W      = 43;
  localparam int LEFT_W       = 11;

  typedef enum logic [0:0] {
    OP_APPEND  = 1'b0,
    OP_CONSUME = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // append a segment
    logic consume;  // accumulate amount, open the search window
    logic probe;    // issue prefix read at the window midpoint
    logic compare;  // narrow the window on the read data
    logic finish;   // register the result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search_done;
  } dp_status_t;

endpackage

/* rtl/csdt_ctrl.sv */
module csdt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                operation,
  input  csdt_pkg::dp_status_t status,
  output csdt_pkg::dp_cmd_t    cmd,
  output logic                busy
);
  import csdt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (op_t'(operation) == OP_CONSUME) begin
            cmd.consume = 1'b1;
            state_next  = ST_PROBE;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (status.search_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.probe  = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_next  = ST_PROBE;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/csdt_datapath.sv */
module csdt_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  csdt_pkg::dp_cmd_t             cmd,
  input  logic [csdt_pkg::AMOUNT_W-1:0] amount,
  output csdt_pkg::dp_status_t          status,
  output logic                          done,
  output logic [csdt_pkg::LEFT_W-1:0]   segments_left
);
  import csdt_pkg::*;

  // entry i (1..MAX) of the prefix table lives at address i-1;
  // entry 0 is always zero and is never probed
  logic [PREFIX_W-1:0] prefix_mem [MAX_SEGMENTS];
  logic [PREFIX_W-1:0] rd_data;
  logic [PREFIX_W-1:0] last_prefix;   // prefix of the newest segment
  logic [CNT_W-1:0]    seg_count;
  logic [TOTAL_W-1:0]  total;
  logic [CNT_W-1:0]    lo;
  logic [CNT_W-1:0]    hi;
  logic [CNT_W-1:0]    mid;
  logic [CNT_W-1:0]    mid_calc;
  logic [CNT_W:0]      span;
  logic                room;
  logic                all_covered;

  assign room        = (seg_count < CNT_W'(MAX_SEGMENTS));
  assign span        = ({1'b0, hi} - {1'b0, lo} + (CNT_W+1)'(1)) >> 1;
  assign mid_calc    = CNT_W'({1'b0, lo} + span);
  assign all_covered = (lo == seg_count);
  assign status.search_done = (lo == hi);

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      prefix_mem[seg_count[ADDR_W-1:0]] <= last_prefix + PREFIX_W'(amount);
    end
    if (cmd.probe) begin
      rd_data <= prefix_mem[ADDR_W'(mid_calc - CNT_W'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count   <= '0;
      last_prefix <= '0;
      total       <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load && room) begin
        seg_count   <= seg_count + CNT_W'(1);
        last_prefix <= last_prefix + PREFIX_W'(amount);
      end
      if (cmd.consume) begin
        total <= total + TOTAL_W'(amount);
      end
      if (cmd.finish && all_covered) begin
        total <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.consume) begin
      lo <= '0;
      hi <= seg_count;
    end
    if (cmd.probe) begin
      mid <= mid_calc;
    end
    if (cmd.compare) begin
      if (TOTAL_W'(rd_data) <= total) begin
        lo <= mid;
      end else begin
        hi <= mid - CNT_W'(1);
      end
    end
    if (cmd.finish) begin
      if (all_covered) begin
        segments_left <= LEFT_W'(seg_count);
      end else begin
        segments_left <= LEFT_W'(seg_count - lo);
      end
    end
  end

endmodule

/* rtl/cumulative_segment_depletion_tracker.sv */
// Append request: taken in one cycle, busy stays low, no result.
// Consume request: busy through P search probes and a finish, P at most
// ceil(log2(count+1)) (11 for a full table), each one RAM read and compare.
// done and segments_left show for exactly one cycle, the first with busy
// low, and cannot be held off; a new request may be taken in that cycle.
// Synchronous reset empties the table and clears the consumed total.
module cumulative_segment_depletion_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [csdt_pkg::AMOUNT_W-1:0] amount,
  output logic                          done,
  output logic [csdt_pkg::LEFT_W-1:0]   segments_left
);
  import csdt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: idle -> (probe -> compare)* -> finish for a consume request.
  csdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Prefix RAM, segment count, consumed total, search window and the
  // output register.
  csdt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .amount        (amount),
    .status        (status),
    .done          (done),
    .segments_left (segments_left)
  );

endmodule

/* test/cumulative_segment_depletion_tracker_tb.sv */
module cumulative_segment_depletion_tracker_tb;

  import csdt_pkg::*;

  // Run length guard: a consume keeps busy only for its search and finish,
  // sender gaps are bounded, and about 1100 requests go in, so this limit
  // leaves a wide margin.
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;

  // One queued request for the driver. drain holds it back until every
  // outstanding result has come out.
  typedef struct {
    op_t                 op;
    logic [AMOUNT_W-1:0] amount;
    bit                  drain;
  } request_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  logic                operation = OP_APPEND;
  logic [AMOUNT_W-1:0] amount    = '0;
  logic                busy;
  logic                done;
  logic [LEFT_W-1:0]   segments_left;

  cumulative_segment_depletion_tracker uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .amount        (amount),
    .done          (done),
    .segments_left (segments_left)
  );

  always #4 clk = ~clk;

  // Requests waiting to be driven, and results still owed by the block.
  request_t          pending_q[$];
  logic [LEFT_W-1:0] segments_left_q[$];

  // Shadow of the block's state, updated as each request is taken.
  logic [PREFIX_W-1:0] prefix_mem [0:MAX_SEGMENTS];
  logic [CNT_W-1:0]    loaded_cnt;
  logic [TOTAL_W-1:0]  consumed_sum;

  int queued_segments = 0;  // appends placed in pending_q (for phase shaping)
  int err_cnt         = 0;
  int cycle_cnt       = 0;
  int n_append        = 0;
  int n_ignored       = 0;
  int n_consume       = 0;
  int n_wrap          = 0;
  int burst_left      = 0;
  int gap_left        = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // Applies one taken request to the shadow state; a consume queues the
  // number of segments it leaves uncovered.
  task automatic track_depletion(input op_t op, input logic [AMOUNT_W-1:0] amt);
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic [CNT_W-1:0] mid;
    if (op == OP_APPEND) begin
      // a full table ignores further appends
      if (loaded_cnt < CNT_W'(MAX_SEGMENTS)) begin
        prefix_mem[loaded_cnt + 1] = prefix_mem[loaded_cnt] + amt;
        loaded_cnt = loaded_cnt + CNT_W'(1);
        n_append++;
      end else begin
        n_ignored++;
      end
    end else begin
      n_consume++;
      consumed_sum = consumed_sum + amt;
      // largest index whose prefix is no more than the total; repeated
      // prefixes (zero-size segments) resolve to the highest such index
      lo = '0;
      hi = loaded_cnt;
      while (lo < hi) begin
        mid = CNT_W'(lo + (hi - lo + CNT_W'(1)) / CNT_W'(2));
        if (prefix_mem[mid] <= consumed_sum) lo = mid;
        else hi = mid - CNT_W'(1);
      end
      // all covered (also the empty table): total restarts, full count out
      if (lo == loaded_cnt) begin
        lo           = '0;
        consumed_sum = '0;
        n_wrap++;
      end
      segments_left_q = {segments_left_q, LEFT_W'(loaded_cnt - lo)};
    end
  endtask

  function automatic void queue_request(input op_t op, input logic [AMOUNT_W-1:0] amt,
                                        input bit drain);
    request_t r;
    r.op     = op;
    r.amount = amt;
    r.drain  = drain;
    pending_q = {pending_q, r};
    if (op == OP_APPEND) queued_segments++;
  endfunction

  // Segment sizes: mostly small so the table total stays within reach of a few
  // large consumes; zero turns up at times, all-ones too when not mostly_small.
  function automatic logic [AMOUNT_W-1:0] segment_size(input bit mostly_small);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (mostly_small) begin
      if (r == 1) return $urandom_range(1, 4096);
      return $urandom_range(1, 16);
    end
    case (r)
      1:       return '1;
      2, 3:    return $urandom;
      4, 5, 6: return $urandom_range(1, 1 << 16);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  function automatic logic [AMOUNT_W-1:0] consume_amount();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 1;
      2, 3:    return '1;
      4, 5:    return $urandom;
      6, 7:    return $urandom_range(1, 64);
      default: return $urandom_range(1, 1 << 20);
    endcase
  endfunction

  // Driver: one nonblocking write per port per edge. A request held while busy
  // stays put; once taken, the next goes up at the same edge if not held back.
  always @(posedge clk) begin : driver
    bit       free;
    request_t nxt;
    free = 1'b1;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        track_depletion(op_t'(operation), amount);
      end else if (start) begin
        free = 1'b0;
      end
      if (free) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain && segments_left_q.size() != 0)) begin
          nxt = pending_q.pop_front();
          start     <= 1'b1;
          operation <= nxt.op;
          amount    <= nxt.amount;
          // bursts of back-to-back requests, then a gap; some gaps are zero
          // so long unbroken stretches occur too
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: the strobe lasts one cycle and cannot be held off.
  always @(posedge clk) begin : monitor
    logic [LEFT_W-1:0] want;
    if (!rst && done) begin
      if (segments_left_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with no consume outstanding", segments_left));
      end else begin
        want = segments_left_q.pop_front();
        if (segments_left !== want)
          report_mismatch($sformatf("segments_left got %0d, want %0d", segments_left, want));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    op_t op;
    for (int i = 0; i <= MAX_SEGMENTS; i++) prefix_mem[i] = '0;
    loaded_cnt   = '0;
    consumed_sum = '0;

    // Directed: empty table, zero-size segments and equal prefixes, extreme
    // amounts, exact and overshooting coverage of the whole table.
    queue_request(OP_CONSUME, '1, 1'b0);          // nothing loaded
    queue_request(OP_CONSUME, '0, 1'b0);          // nothing loaded, zero amount
    queue_request(OP_APPEND,  '0, 1'b0);          // zero-size segment
    queue_request(OP_CONSUME, '0, 1'b1);          // zero covers it: wrap, 1 left
    queue_request(OP_APPEND,  5, 1'b0);
    queue_request(OP_APPEND,  '0, 1'b0);          // repeated prefix
    queue_request(OP_APPEND,  '1, 1'b0);
    queue_request(OP_APPEND,  1, 1'b0);
    queue_request(OP_CONSUME, 4, 1'b1);
    queue_request(OP_CONSUME, 1, 1'b0);           // lands on the repeated prefix
    queue_request(OP_CONSUME, '0, 1'b0);
    queue_request(OP_CONSUME, '1, 1'b0);
    queue_request(OP_CONSUME, 1, 1'b0);           // exact cover: wrap
    queue_request(OP_CONSUME, '1, 1'b0);
    queue_request(OP_CONSUME, '1, 1'b0);          // overshoot: wrap
    queue_request(OP_APPEND,  32'hAAAAAAAA, 1'b0);
    queue_request(OP_APPEND,  32'h55555555, 1'b0);
    queue_request(OP_CONSUME, 32'h80000000, 1'b0);
    queue_request(OP_CONSUME, 32'h7FFFFFFF, 1'b0);
    queue_request(OP_CONSUME, 32'h00000001, 1'b1);

    // Random, shallow table: even mix of appends and consumes.
    for (int i = 0; i < 40; i++) begin
      op = ($urandom_range(0, 1) == 0) ? OP_APPEND : OP_CONSUME;
      queue_request(op, (op == OP_APPEND) ? segment_size(1'b0) : consume_amount(),
                    $urandom_range(0, 49) == 0);
    end

    // Random fill up to capacity, consumes sprinkled in.
    while (queued_segments < MAX_SEGMENTS) begin
      if ($urandom_range(0, 24) == 0) queue_request(OP_CONSUME, consume_amount(),
                                                    $urandom_range(0, 49) == 0);
      else queue_request(OP_APPEND, segment_size(1'b1), 1'b0);
    end

    // Full table: appends must be ignored.
    queue_request(OP_APPEND,  '1, 1'b1);
    queue_request(OP_APPEND,  '0, 1'b0);
    queue_request(OP_APPEND,  $urandom, 1'b0);
    queue_request(OP_CONSUME, '0, 1'b0);

    // Random at capacity: consumes lean towards large amounts so the whole
    // table gets covered and the total restarts.
    for (int i = 0; i < 30; i++) begin
      op = ($urandom_range(0, 3) == 0) ? OP_APPEND : OP_CONSUME;
      queue_request(op, (op == OP_APPEND) ? segment_size(1'b0) :
                    (($urandom_range(0, 2) == 0) ? '1 : consume_amount()),
                    $urandom_range(0, 49) == 0);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // every request taken, every result in, then a tail for stray strobes
    while (pending_q.size() != 0 || start) @(posedge clk);
    while (segments_left_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d appends (%0d ignored on a full table) and %0d consumes,",
             n_append, n_ignored, n_consume);
    $display("%0d of which covered every loaded segment; %0d mismatches.", n_wrap, err_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
